FILE: rtl/disk_seek_scheduler_defines.svh
// ----------------------------------------------------------------------------
// disk seek scheduler assertion macros
// assertion shorthands for the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef DISK_SEEK_SCHEDULER_DEFINES_SVH
`define DISK_SEEK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define DSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dss assertion failed");
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dss assertion failed");
`else
`define DSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// types and codes of the disk seek scheduler
// ----------------------------------------------------------------------------
`default_nettype none
package dss_pkg;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FIELD_CYL_W  = 16;
    localparam int FIELD_SEEK_W = 22;
    localparam int SEEK_W       = 23;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD = 2'd1;

    typedef enum logic [1:0] {
        MODE_FCFS  = 2'd0,
        MODE_SSTF  = 2'd1,
        MODE_LOOK  = 2'd2,
        MODE_CLOOK = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/dss_if.sv
// ----------------------------------------------------------------------------
// dss channel interfaces
// request, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none
interface dss_req_if;
    import dss_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [FIELD_CYL_W-1:0] cylinder;
    logic                   last_request;
    modport source (output valid, cylinder, last_request, input ready);
    modport sink   (input valid, cylinder, last_request, output ready);
endinterface

interface dss_res_if;
    import dss_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [FIELD_CYL_W-1:0]  served_cylinder;
    logic [FIELD_SEEK_W-1:0] total_seek;
    logic                    dropped_flag;
    logic                    last_result;
    modport source (output valid, served_cylinder, total_seek, dropped_flag, last_result,
                    input ready);
    modport sink   (input valid, served_cylinder, total_seek, dropped_flag, last_result,
                    output ready);
endinterface

interface dss_cfg_if;
    import dss_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module dss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/disk_seek_scheduler.sv
// after the final request of a batch, each result comes from one scan pass over
// the stored requests through the single read port of the request ram, each entry
// compared as its read returns, then a selection state that waits for the output
// non-final requests are only stored; the ram is not cleared, a fill count tracks it
// synchronous active-low reset clears count, served marks, head, mode and output valid
// ----------------------------------------------------------------------------
// disk_seek_scheduler
// fcfs / sstf / look / c-look seek ordering over a batch of cylinder requests
// ----------------------------------------------------------------------------
`default_nettype none
`include "disk_seek_scheduler_defines.svh"
module disk_seek_scheduler
    import dss_pkg::*;
#(
    parameter int MAX_REQUESTS = 64,
    parameter int CYL_BITS     = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    dss_req_if.sink   i_req,
    dss_res_if.source o_res,
    dss_cfg_if.sink   i_cfg
);
    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

    t_state r_state, n_state;
    t_mode  r_mode;
    logic [FIELD_CYL_W-1:0] r_start;
    logic [CNT_W-1:0]       r_count, r_k;
    logic [MAX_REQUESTS-1:0] r_served;
    logic                   r_ovf;
    logic [CYL_BITS-1:0]    r_head;
    logic [SEEK_W-1:0]      r_seek;

    logic [IDX_W-1:0] r_iss_idx, r_cmp_idx;
    logic             r_iss_done, r_cmp_v;
    logic             r_best_v, r_alt_v;
    logic [IDX_W-1:0] r_best_idx, r_alt_idx;
    logic [CYL_BITS-1:0] r_best_val, r_alt_val, r_best_d;

    logic [CYL_BITS-1:0] rd_data, sh_ext, cyl_ext, cmp_d, sel_val, sel_d;
    logic [IDX_W-1:0]    sel_idx;
    logic                accept, out_free, is_last_cmp, is_last_k;
    logic [31:0]         out_ext, d_ext;

    assign sh_ext  = CYL_BITS'(32'(r_start));
    assign cyl_ext = CYL_BITS'(32'(i_req.cylinder));
    assign accept  = i_req.valid && i_req.ready;
    assign out_free = !o_res.valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign is_last_cmp = (CNT_W'(r_cmp_idx) == r_count - CNT_W'(1));
    assign is_last_k   = (r_k + CNT_W'(1) == r_count);

    dss_ram #(.WIDTH(CYL_BITS), .DEPTH(MAX_REQUESTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (accept && (r_count < CNT_MAX)),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(cyl_ext),
        .i_raddr(r_iss_idx),
        .o_rdata(rd_data)
    );

    assign cmp_d = (r_head > rd_data) ? r_head - rd_data : rd_data - r_head;

    // up phase winner if any, else the down-sweep (look) or wrap-around (c-look) candidate
    always_comb begin
        sel_idx = r_best_v ? r_best_idx : r_alt_idx;
        sel_val = r_best_v ? r_best_val : r_alt_val;
        sel_d   = (r_head > sel_val) ? r_head - sel_val : sel_val - r_head;
        d_ext   = 32'(sel_d);
        out_ext = 32'(sel_val);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept && i_req.last_request) n_state = S_SCAN;
            S_SCAN: if (r_cmp_v && is_last_cmp) n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = is_last_k ? S_IDLE : S_SCAN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_FCFS;
            r_start  <= '0;
            r_count  <= '0;
            r_k      <= '0;
            r_served <= '0;
            r_ovf    <= 1'b0;
            r_head   <= '0;
            r_seek   <= '0;
            r_iss_done <= 1'b0;
            r_cmp_v  <= 1'b0;
            r_best_v <= 1'b0;
            r_alt_v  <= 1'b0;
            o_res.valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_MODE) r_mode <= t_mode'(i_cfg.data[1:0]);
                else if (i_cfg.index == REG_HEAD) r_start <= i_cfg.data;
            end
            if (o_res.valid && o_res.ready) o_res.valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_count < CNT_MAX) r_count <= r_count + CNT_W'(1);
                        else r_ovf <= 1'b1;
                        if (i_req.last_request) begin
                            r_k        <= '0;
                            r_head     <= sh_ext;
                            r_seek     <= '0;
                            r_iss_idx  <= '0;
                            r_iss_done <= 1'b0;
                            r_cmp_v    <= 1'b0;
                            r_best_v   <= 1'b0;
                            r_alt_v    <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    // issue one read a cycle, compare the returned entry next cycle
                    r_cmp_v   <= !r_iss_done;
                    r_cmp_idx <= r_iss_idx;
                    if (!r_iss_done) begin
                        if (CNT_W'(r_iss_idx) == r_count - CNT_W'(1)) r_iss_done <= 1'b1;
                        else r_iss_idx <= r_iss_idx + IDX_W'(1);
                    end
                    if (r_cmp_v && !r_served[r_cmp_idx]) begin
                        case (r_mode)
                            MODE_FCFS: begin
                                if (CNT_W'(r_cmp_idx) == r_k) begin
                                    r_best_v <= 1'b1; r_best_idx <= r_cmp_idx;
                                    r_best_val <= rd_data;
                                end
                            end
                            MODE_SSTF: begin
                                if (!r_best_v || cmp_d < r_best_d) begin
                                    r_best_v <= 1'b1; r_best_idx <= r_cmp_idx;
                                    r_best_val <= rd_data; r_best_d <= cmp_d;
                                end
                            end
                            default: begin
                                if (rd_data >= sh_ext &&
                                    (!r_best_v || rd_data < r_best_val)) begin
                                    r_best_v <= 1'b1; r_best_idx <= r_cmp_idx;
                                    r_best_val <= rd_data;
                                end
                                if (!r_alt_v ||
                                    (r_mode == MODE_LOOK  && rd_data > r_alt_val) ||
                                    (r_mode == MODE_CLOOK && rd_data < r_alt_val)) begin
                                    r_alt_v <= 1'b1; r_alt_idx <= r_cmp_idx;
                                    r_alt_val <= rd_data;
                                end
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_res.valid           <= 1'b1;
                        o_res.served_cylinder <= out_ext[FIELD_CYL_W-1:0];
                        o_res.total_seek      <= FIELD_SEEK_W'(r_seek + d_ext[SEEK_W-1:0]);
                        o_res.dropped_flag    <= r_ovf;
                        o_res.last_result     <= is_last_k;
                        r_seek     <= r_seek + d_ext[SEEK_W-1:0];
                        r_head     <= sel_val;
                        r_served[sel_idx] <= 1'b1;
                        r_k        <= r_k + CNT_W'(1);
                        r_iss_idx  <= '0;
                        r_iss_done <= 1'b0;
                        r_cmp_v    <= 1'b0;
                        r_best_v   <= 1'b0;
                        r_alt_v    <= 1'b0;
                        if (is_last_k) begin
                            r_count  <= '0;
                            r_served <= '0;
                            r_ovf    <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `DSS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX)
    `DSS_ASSERT_IMPL(a_done_has_pick, i_clk, i_rst_n, r_state == S_DONE, r_best_v || r_alt_v)
    `DSS_ASSERT_IMPL(a_scan_k_range, i_clk, i_rst_n, r_state == S_SCAN, r_k < r_count)
endmodule
`default_nettype wire

FILE: dv/dss_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disk seek scheduler checker
// watches the request, result and configuration channels, predicts the
// service order of every batch and compares each result item in order
// ----------------------------------------------------------------------------
module dss_checker
    import dss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dss_req_if   req,
    dss_res_if   res,
    dss_cfg_if   cfg,
    output int   o_pending,
    output int   o_fail_count
);
    localparam int DEPTH = 64;

    typedef struct packed {
        logic [FIELD_CYL_W-1:0]  cyl;
        logic [FIELD_SEEK_W-1:0] seek;
        logic                    dropped;
        logic                    last;
    } t_served;

    t_served                expected_order[$];
    logic [FIELD_CYL_W-1:0] cyl_store[DEPTH];
    bit                     done_mark[DEPTH];
    int                     fill;
    bit                     overflow;
    t_mode                  mode;
    logic [FIELD_CYL_W-1:0] head_start;
    int                     fail_count;

    assign o_pending    = expected_order.size();
    assign o_fail_count = fail_count;

    function automatic logic [FIELD_CYL_W-1:0] gap(logic [FIELD_CYL_W-1:0] a,
                                                   logic [FIELD_CYL_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // lowest unserved cylinder, optionally only those at or above the floor
    function automatic int lowest(bit above, logic [FIELD_CYL_W-1:0] floor_cyl);
        int best;
        best = -1;
        for (int j = 0; j < fill; j++) begin
            if (done_mark[j] || (above && cyl_store[j] < floor_cyl)) continue;
            if (best < 0 || cyl_store[j] < cyl_store[best]) best = j;
        end
        return best;
    endfunction

    function automatic int highest();
        int best;
        best = -1;
        for (int j = 0; j < fill; j++) begin
            if (done_mark[j]) continue;
            if (best < 0 || cyl_store[j] > cyl_store[best]) best = j;
        end
        return best;
    endfunction

    function automatic int nearest(logic [FIELD_CYL_W-1:0] at);
        int best;
        best = -1;
        for (int j = 0; j < fill; j++) begin
            if (done_mark[j]) continue;
            if (best < 0 || gap(at, cyl_store[j]) < gap(at, cyl_store[best])) best = j;
        end
        return best;
    endfunction

    task automatic schedule_batch();
        logic [FIELD_CYL_W-1:0] at;
        logic [SEEK_W-1:0]      travel;
        int                     idx;
        t_served                item;
        at     = head_start;
        travel = '0;
        for (int k = 0; k < fill; k++) begin
            case (mode)
                MODE_FCFS: idx = k;
                MODE_SSTF: idx = nearest(at);
                MODE_LOOK: begin
                    idx = lowest(1'b1, head_start);
                    if (idx < 0) idx = highest();
                end
                default: begin
                    idx = lowest(1'b1, head_start);
                    if (idx < 0) idx = lowest(1'b0, '0);
                end
            endcase
            if (idx < 0) idx = 0;
            done_mark[idx] = 1'b1;
            travel         = travel + gap(at, cyl_store[idx]);
            at             = cyl_store[idx];
            item.cyl       = at;
            item.seek      = travel[FIELD_SEEK_W-1:0];
            item.dropped   = overflow;
            item.last      = (k + 1 == fill);
            expected_order.push_back(item);
        end
        fill     = 0;
        overflow = 1'b0;
        foreach (done_mark[j]) done_mark[j] = 1'b0;
    endtask

    task automatic report(string what, int got, int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_served want;
        if (!i_rst_n) begin
            fill       = 0;
            overflow   = 1'b0;
            mode       = MODE_FCFS;
            head_start = '0;
            foreach (done_mark[j]) done_mark[j] = 1'b0;
            expected_order.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_MODE) mode = t_mode'(cfg.data[1:0]);
                else if (cfg.index == REG_HEAD) head_start = cfg.data;
            end
            if (req.valid && req.ready) begin
                if (fill < DEPTH) begin
                    cyl_store[fill] = req.cylinder;
                    done_mark[fill] = 1'b0;
                    fill++;
                end else begin
                    overflow = 1'b1;
                end
                if (req.last_request) schedule_batch();
            end
            if (res.valid && res.ready) begin
                if (expected_order.size() == 0) begin
                    report("unexpected result, cylinder", res.served_cylinder, -1);
                end else begin
                    want = expected_order.pop_front();
                    if (res.served_cylinder !== want.cyl)
                        report("served_cylinder", res.served_cylinder, want.cyl);
                    if (res.total_seek !== want.seek)
                        report("total_seek", res.total_seek, want.seek);
                    if (res.dropped_flag !== want.dropped)
                        report("dropped_flag", res.dropped_flag, want.dropped);
                    if (res.last_result !== want.last)
                        report("last_result", res.last_result, want.last);
                end
            end
        end
    end
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disk seek scheduler testbench
// directed and random request batches in all four seek modes with random
// gaps and stalls; a checker beside the block predicts every result item
// ----------------------------------------------------------------------------
module testbench;
    import dss_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = 2'd3;
    localparam int SETTLE = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   pending;
    int   fail_count;
    int   sent = 0;
    bit   hold_results = 1'b0;
    bit   eager_send = 1'b0;
    bit   eager_take = 1'b0;
    logic [FIELD_CYL_W-1:0] cur_head = '0;

    dss_req_if req ();
    dss_res_if res ();
    dss_cfg_if cfg ();

    disk_seek_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    dss_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .res          (res),
        .cfg          (cfg),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req.valid = 1'b0;
        req.cylinder = '0;
        req.last_request = 1'b0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
    end

    task automatic send_req(logic [FIELD_CYL_W-1:0] cyl, bit last);
        int wait_cycles;
        wait_cycles = eager_send ? 0 : $urandom_range(6);
        if (wait_cycles > 0) begin
            req.valid <= 1'b0;
            repeat (wait_cycles) @(posedge i_clk);
        end
        req.valid        <= 1'b1;
        req.cylinder     <= cyl;
        req.last_request <= last;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        if (idx == REG_HEAD) cur_head = value;
    endtask

    // sender stays quiet until the block has drained and gone idle
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [FIELD_CYL_W-1:0] pick_cyl();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return cur_head;
            3, 4: return FIELD_CYL_W'(32'(cur_head) + $urandom_range(40) - 32'd20);
            default: return FIELD_CYL_W'($urandom);
        endcase
    endfunction

    task automatic send_batch(int n);
        for (int i = 0; i < n; i++) send_req(pick_cyl(), i == n - 1);
    endtask

    // results side: random stalls, calm stretches, long hold-offs
    initial begin
        int wait_cycles;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_results) begin
                res.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_results = 1'b0;
            end
            wait_cycles = eager_take ? 0 : $urandom_range(6);
            if (wait_cycles > 0) begin
                res.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            @(posedge i_clk);
            while (!res.valid && !hold_results) @(posedge i_clk);
        end
    end

    initial begin
        #10ms;
        $display("disk_seek_scheduler: mismatch");
        $finish;
    end

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every mode over extremes, ties and a single-entry batch
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_MODE, CFG_DATA_W'(m));
            write_reg(REG_HEAD, 16'd100);
            send_req(16'd90, 1'b0);
            send_req(16'd110, 1'b0);
            send_req(16'hFFFF, 1'b0);
            send_req(16'd0, 1'b0);
            send_req(16'd100, 1'b1);
            drain();
        end
        write_reg(REG_MODE, CFG_DATA_W'(MODE_LOOK));
        write_reg(REG_HEAD, 16'hFFFF);
        send_req(16'd5, 1'b0);
        send_req(16'hFFFF, 1'b1);
        drain();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_CLOOK));
        write_reg(REG_HEAD, 16'd0);
        send_req(16'h1234, 1'b1);
        drain();
        // unused register indexes must leave the settings alone
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_TOP, 16'h5555);
        send_req(16'hAAAA, 1'b0);
        send_req(16'h5555, 1'b1);
        drain();
        // over capacity, the final item itself is dropped
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SSTF));
        write_reg(REG_HEAD, 16'h8000);
        for (int i = 0; i < 67; i++) send_req(FIELD_CYL_W'($urandom), i == 66);
        drain();

        // random batches, settings changed between phases
        while (sent < 430) begin
            write_reg(REG_MODE, CFG_DATA_W'($urandom_range(3)));
            case ($urandom_range(3))
                0: write_reg(REG_HEAD, '0);
                1: write_reg(REG_HEAD, '1);
                default: write_reg(REG_HEAD, CFG_DATA_W'($urandom));
            endcase
            eager_send = ($urandom_range(3) == 0);
            eager_take = ($urandom_range(3) == 0);
            for (int b = 0; b < 4; b++) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(60, 66) :
                    ($urandom_range(3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                if (sent > 200 && sent < 230) hold_results = 1'b1;
                send_batch(n);
            end
            drain();
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("disk_seek_scheduler: match");
        end else begin
            $display("disk_seek_scheduler: mismatch");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/dss_pkg.sv
rtl/dss_if.sv
rtl/dss_ram.sv
rtl/disk_seek_scheduler.sv
dv/dss_checker.sv
dv/testbench.sv
